// ===== hdl/cscan_request_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// cscan request scheduler assertion macros
// shared concurrent checks, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef CSCAN_REQUEST_SCHEDULER_DEFINES_SVH
`define CSCAN_REQUEST_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define CSCAN_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSCAN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cscan_pkg.sv =====
// ----------------------------------------------------------------------------
// cscan_pkg
// shared constants, codes and types of the c-scan request scheduler
// ----------------------------------------------------------------------------
package cscan_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TRACK_BITS  = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int FIELD_BITS  = 16;
    localparam int TAG_BITS    = 16;
    localparam int PEND_BITS   = 6;

    // request functions
    localparam logic FUNC_INSERT   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED   = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    typedef struct packed {
        logic                  func;
        logic [FIELD_BITS-1:0] request_track;
        logic [TAG_BITS-1:0]   request_tag;
    } request_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] served_track;
        logic [TAG_BITS-1:0]   served_tag;
        logic [PEND_BITS-1:0]  pending_count;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic insert;
        logic dispatch;
        logic reject;
    } cscan_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic full;
        logic empty;
    } cscan_stat_t;

endpackage

// ===== hdl/cscan_ctrl.sv =====
// ----------------------------------------------------------------------------
// cscan_ctrl
// sequencer: load, compare, update for each request
// ----------------------------------------------------------------------------
module cscan_ctrl
    import cscan_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cscan_stat_t stat,
    output logic        busy,
    output cscan_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_COMPARE;
                        busy_reg  <= 1'b1;
                    end
                end
                S_COMPARE:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == S_IDLE) && start;
        case (state_reg)
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
            end
            S_UPDATE:
            begin
                if (stat.func == FUNC_INSERT)
                begin
                    cmd.insert = !stat.full;
                    cmd.reject = stat.full;
                end
                else
                begin
                    cmd.dispatch = !stat.empty;
                    cmd.reject   = stat.empty;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy = busy_reg;

endmodule

// ===== hdl/cscan_dp.sv =====
// ----------------------------------------------------------------------------
// cscan_dp
// sorted entry row with per-cell compare and shift, head and result registers
// ----------------------------------------------------------------------------
module cscan_dp
    import cscan_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  request_t    req,
    input  cscan_cmd_t  cmd,
    output cscan_stat_t stat,
    output logic        done,
    output result_t     result
);

    logic                  func_reg;
    logic [TRACK_BITS-1:0] trk_reg;
    logic [TAG_BITS-1:0]   tag_reg;

    logic [TRACK_BITS-1:0] track_reg   [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0] track_next  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   tag_row_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   tag_row_next[QUEUE_DEPTH];

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;

    logic [QUEUE_DEPTH-1:0] valid;
    logic [QUEUE_DEPTH-1:0] le_reg, le_next;
    logic [QUEUE_DEPTH-1:0] ge_reg, ge_next;
    logic                   any_ge_reg;
    logic [QUEUE_DEPTH-1:0] sel;

    logic [TRACK_BITS-1:0] pick_track;
    logic [TAG_BITS-1:0]   pick_tag;

    result_t result_reg, result_next;
    logic    done_reg;

    // per-cell compares; sorted order makes le a thermometer code and ge a single run
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            valid[i]   = CNT_BITS'(i) < count_reg;
            le_next[i] = valid[i] && (track_reg[i] <= trk_reg);
            ge_next[i] = valid[i] && (track_reg[i] >= head_reg);
        end
    end

    // first entry at or past the head, else wrap to the lowest track
    always_comb
    begin
        sel[0] = ge_reg[0] || !any_ge_reg;
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            sel[i] = ge_reg[i] && !ge_reg[i-1];
        end
    end

    always_comb
    begin
        pick_track = '0;
        pick_tag   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            pick_track = pick_track | ({TRACK_BITS{sel[i]}} & track_reg[i]);
            pick_tag   = pick_tag | ({TAG_BITS{sel[i]}} & tag_row_reg[i]);
        end
    end

    // cell moves: insert shifts up past the insert point, dispatch shifts down
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            track_next[i]   = track_reg[i];
            tag_row_next[i] = tag_row_reg[i];
        end
        if (cmd.insert)
        begin
            if (!le_reg[0])
            begin
                track_next[0]   = trk_reg;
                tag_row_next[0] = tag_reg;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (!le_reg[i])
                begin
                    if (le_reg[i-1])
                    begin
                        track_next[i]   = trk_reg;
                        tag_row_next[i] = tag_reg;
                    end
                    else
                    begin
                        track_next[i]   = track_reg[i-1];
                        tag_row_next[i] = tag_row_reg[i-1];
                    end
                end
            end
        end
        else if (cmd.dispatch)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (!(any_ge_reg && !ge_reg[i]))
                begin
                    track_next[i]   = track_reg[i+1];
                    tag_row_next[i] = tag_row_reg[i+1];
                end
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        head_next   = head_reg;
        result_next = result_reg;
        if (cmd.insert)
        begin
            count_next                = count_reg + CNT_BITS'(1);
            result_next.status        = ST_INSERTED;
            result_next.served_track  = '0;
            result_next.served_tag    = '0;
            result_next.pending_count = PEND_BITS'(count_next);
        end
        else if (cmd.dispatch)
        begin
            count_next                = count_reg - CNT_BITS'(1);
            head_next                 = pick_track;
            result_next.status        = ST_DISPATCHED;
            result_next.served_track  = FIELD_BITS'(pick_track);
            result_next.served_tag    = pick_tag;
            result_next.pending_count = PEND_BITS'(count_next);
        end
        else if (cmd.reject)
        begin
            result_next.status        = (func_reg == FUNC_DISPATCH) ? ST_EMPTY : ST_FULL;
            result_next.served_track  = '0;
            result_next.served_tag    = '0;
            result_next.pending_count = PEND_BITS'(count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req.func;
            trk_reg  <= TRACK_BITS'(req.request_track);
            tag_reg  <= req.request_tag;
        end
        if (cmd.compare)
        begin
            le_reg     <= le_next;
            ge_reg     <= ge_next;
            any_ge_reg <= |ge_next;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            track_reg[i]   <= track_next[i];
            tag_row_reg[i] <= tag_row_next[i];
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            done_reg  <= cmd.insert || cmd.dispatch || cmd.reject;
        end
    end

    assign stat.func  = func_reg;
    assign stat.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign done       = done_reg;
    assign result     = result_reg;

endmodule

// ===== hdl/cscan_request_scheduler.sv =====
// ----------------------------------------------------------------------------
// cscan_request_scheduler
// c-scan request queue: sorted insert by track, dispatch of the next track
// at or past the head with wrap to the lowest track
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start & !busy      req    (func, request_track, request_tag)
//  result    done (one cycle)   result (status, served_track, served_tag,
//                                       pending_count)
//
//  a request runs through an accept edge, a compare edge (all cells compare
//  against the request track and the head at once) and an update edge (cells
//  shift, result registered); done is high in the cycle after and busy is
//  already low there, so a new request is taken only after the update edge
//  reset clears the entry count, the head and the sequencer; no clearing pass
//  results cannot be stalled: each is shown for exactly one cycle on done
// ----------------------------------------------------------------------------
`include "cscan_request_scheduler_defines.svh"

module cscan_request_scheduler
    import cscan_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t req,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    // command and status between sequencer and datapath
    cscan_cmd_t  cmd;
    cscan_stat_t stat;

    // sequencer: one request at a time
    cscan_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // sorted entry row, head position and result register
    cscan_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

    // result appears only after the sequencer has gone idle
    `CSCAN_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")

    // an accepted request holds the block busy in the next cycle
    `CSCAN_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done,
        "accepted request did not start")

    // a full rejection reports the whole queue and no served request
    `CSCAN_ASSERT_NOW(a_full_count, done && (result.status == ST_FULL),
        (result.pending_count == PEND_BITS'(QUEUE_DEPTH)) && (result.served_tag == '0),
        "full status with wrong count or served fields")

    // an empty rejection reports no pending requests
    `CSCAN_ASSERT_NOW(a_empty_count, done && (result.status == ST_EMPTY),
        (result.pending_count == '0) && (result.served_track == '0),
        "empty status with pending requests")

endmodule
